FILE: src/wlfc_pkg.sv
package wlfc_pkg;

    localparam int CW_X   = 24;
    localparam int CW_SG  = 16;
    localparam int CW_W   = 32;
    localparam int CW_CHI = 40;
    localparam int CW_OUT = 32;

    // front weight divider: quotient bits per cycle and cycle count
    localparam int DIV_STEPS = 4;
    localparam int DIV_CYC   = CW_W / DIV_STEPS;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_ZSIG  = 2'd1;
    localparam logic [1:0] STAT_DEGEN = 2'd2;
    localparam logic [1:0] STAT_OVER  = 2'd3;

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    typedef struct packed {
        logic signed [CW_X-1:0] x;
        logic signed [CW_X-1:0] y;
        logic [CW_W-1:0]        w;
        logic                   last;
        logic                   drop;
        logic                   zs;
        logic                   ovf;
    } t_pt;

    typedef struct packed {
        logic [CW_CHI-1:0]        chi;
        logic signed [CW_OUT-1:0] a;
        logic signed [CW_OUT-1:0] b;
        logic signed [CW_OUT-1:0] res;
        logic [2:0]               idx;
        logic [1:0]               status;
        logic                     last;
    } t_res;

    typedef struct packed {
        logic         start;
        logic         op;
        logic [127:0] a;
        logic [127:0] b;
        logic [7:0]   len;
    } t_alu_req;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
        logic [31:0]  quot;
    } t_alu_rsp;

endpackage

FILE: src/wlfc_fifo.sv
module wlfc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;
    logic             push_ok, pop_ok;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + PW'(1);
            end
            if (pop_ok) begin
                r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + PW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end
endmodule

FILE: src/wlfc_front.sv
module wlfc_front #(
    parameter int MAX_POINTS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic signed [23:0]    i_x,
    input  logic signed [23:0]    i_y,
    input  logic [15:0]           i_sigma,
    input  logic                  i_last,
    output logic                  o_q_push,
    output wlfc_pkg::t_pt         o_q_data,
    input  logic                  i_q_full
);
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_DIV  = 2'd1;
    localparam logic [1:0] FS_PUSH = 2'd2;

    logic [1:0]    r_st;
    logic [CW-1:0] r_cnt;
    logic          r_zs, r_ovf;
    wlfc_pkg::t_pt r_ent;
    logic [31:0]   r_dv, r_rem, r_q;
    logic [2:0]    r_dc;

    logic          accept, stored, zs_n, ovf_n;
    logic [31:0]   n_rem, n_q;
    logic [32:0]   t;

    assign o_full   = (r_st != FS_IDLE);
    assign accept   = i_push && !o_full;
    assign stored   = (r_cnt < CW'(MAX_POINTS));
    assign zs_n     = r_zs | (stored && (i_sigma == '0));
    assign ovf_n    = r_ovf | !stored;
    assign o_q_push = (r_st == FS_PUSH);
    assign o_q_data = r_ent;

    // restoring division of all-ones by sigma^2, DIV_STEPS quotient bits per cycle
    always_comb begin
        n_rem = r_rem;
        n_q   = r_q;
        t     = '0;
        for (int k = 0; k < wlfc_pkg::DIV_STEPS; k++) begin
            t = {n_rem, 1'b1};
            if (t >= {1'b0, r_dv}) begin
                t = t - {1'b0, r_dv};
                n_q = {n_q[30:0], 1'b1};
            end else begin
                n_q = {n_q[30:0], 1'b0};
            end
            n_rem = t[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= FS_IDLE;
            r_cnt <= '0;
            r_zs  <= 1'b0;
            r_ovf <= 1'b0;
        end else begin
            unique case (r_st)
                FS_IDLE: begin
                    if (accept) begin
                        if (i_last) begin
                            r_cnt <= '0;
                            r_zs  <= 1'b0;
                            r_ovf <= 1'b0;
                        end else begin
                            r_zs  <= zs_n;
                            r_ovf <= ovf_n;
                            if (stored) begin
                                r_cnt <= r_cnt + CW'(1);
                            end
                        end
                        if (stored && (i_sigma != '0)) begin
                            r_st <= FS_DIV;
                        end else if (stored || i_last) begin
                            r_st <= FS_PUSH;
                        end
                    end
                end
                FS_DIV: begin
                    if (r_dc == 3'(wlfc_pkg::DIV_CYC - 1)) begin
                        r_st <= FS_PUSH;
                    end
                end
                FS_PUSH: begin
                    if (!i_q_full) begin
                        r_st <= FS_IDLE;
                    end
                end
                default: r_st <= FS_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ent.x    <= i_x;
            r_ent.y    <= i_y;
            r_ent.w    <= '0;
            r_ent.last <= i_last;
            r_ent.drop <= !stored;
            r_ent.zs   <= zs_n;
            r_ent.ovf  <= ovf_n;
            r_dv       <= 32'(i_sigma) * 32'(i_sigma);
            r_rem      <= '0;
            r_q        <= '0;
            r_dc       <= '0;
        end else if (r_st == FS_DIV) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            r_dc  <= r_dc + 3'd1;
            if (r_dc == 3'(wlfc_pkg::DIV_CYC - 1)) begin
                r_ent.w <= n_q;
            end
        end
    end
endmodule

FILE: src/wlfc_alu.sv
module wlfc_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wlfc_pkg::t_alu_req i_req,
    output wlfc_pkg::t_alu_rsp o_rsp
);
    logic         r_busy, r_done, r_op, r_neg, r_big;
    logic [7:0]   r_cnt;
    logic [127:0] r_m, r_b, r_acc;
    logic [40:0]  r_q;

    logic [127:0] ma, mb;
    logic [128:0] dt, dd;
    logic         ge;
    logic [41:0]  qn, qm;
    logic [31:0]  quot;

    always_comb begin
        ma = i_req.a[127] ? (~i_req.a + 128'd1) : i_req.a;
        mb = (i_req.op == wlfc_pkg::OP_MUL && i_req.b[127]) ? (~i_req.b + 128'd1) : i_req.b;
        dt = {r_acc, r_m[127]};
        ge = (dt >= {1'b0, r_b});
        dd = dt - {1'b0, r_b};
        qn = {r_q, ge};
        qm = r_big ? (42'd1 << 40) : ((42'(r_q) + 42'd1) >> 1);
        if (r_neg) begin
            quot = (qm > 42'h0_8000_0000) ? 32'h8000_0000 : (~qm[31:0] + 32'd1);
        end else begin
            quot = (qm > 42'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : qm[31:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_neg ? (~r_acc + 128'd1) : r_acc;
    assign o_rsp.quot = quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 8'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_op  <= i_req.op;
            r_cnt <= i_req.len;
            r_m   <= ma;
            r_b   <= mb;
            r_acc <= '0;
            r_q   <= '0;
            r_big <= 1'b0;
            r_neg <= (i_req.op == wlfc_pkg::OP_MUL) ? (i_req.a[127] ^ i_req.b[127])
                                                    : i_req.a[127];
        end else if (r_busy) begin
            r_cnt <= r_cnt - 8'd1;
            r_m   <= r_m << 1;
            if (r_op == wlfc_pkg::OP_MUL) begin
                r_b <= r_b >> 1;
                if (r_b[0]) begin
                    r_acc <= r_acc + r_m;
                end
            end else begin
                r_acc <= ge ? dd[127:0] : dt[127:0];
                if (!r_big) begin
                    r_q <= qn[40:0];
                    // quotient past 2^40 saturates anyway
                    if (qn[41:40] != 2'b00) begin
                        r_big <= 1'b1;
                    end
                end
            end
        end
    end
endmodule

FILE: src/wlfc_back.sv
module wlfc_back #(
    parameter int MAX_POINTS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  wlfc_pkg::t_pt      i_q_data,
    output wlfc_pkg::t_alu_req o_alu_req,
    input  wlfc_pkg::t_alu_rsp i_alu_rsp,
    output logic               o_r_push,
    output wlfc_pkg::t_res     o_r_data,
    input  logic               i_r_full
);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(MAX_POINTS);

    localparam logic [7:0] LEN_XY    = 8'd24;
    localparam logic [7:0] LEN_S     = 8'd40;
    localparam logic [7:0] LEN_X     = 8'd64;
    localparam logic [7:0] LEN_SLOPE = 8'd32;
    localparam logic [7:0] LEN_W     = 8'd32;
    localparam logic [7:0] LEN_DIV_B = 8'd145;
    localparam logic [7:0] LEN_DIV_A = 8'd129;

    localparam logic [4:0] BS_IDLE = 5'd0;
    localparam logic [4:0] BS_WX   = 5'd1;
    localparam logic [4:0] BS_WY   = 5'd2;
    localparam logic [4:0] BS_XX   = 5'd3;
    localparam logic [4:0] BS_XY   = 5'd4;
    localparam logic [4:0] BS_FIT  = 5'd5;
    localparam logic [4:0] BS_D1   = 5'd6;
    localparam logic [4:0] BS_D2   = 5'd7;
    localparam logic [4:0] BS_N1   = 5'd8;
    localparam logic [4:0] BS_N2   = 5'd9;
    localparam logic [4:0] BS_CHK  = 5'd10;
    localparam logic [4:0] BS_B    = 5'd11;
    localparam logic [4:0] BS_XB   = 5'd12;
    localparam logic [4:0] BS_A    = 5'd13;
    localparam logic [4:0] BS_RF   = 5'd14;
    localparam logic [4:0] BS_BX   = 5'd15;
    localparam logic [4:0] BS_RSQ  = 5'd16;
    localparam logic [4:0] BS_RW   = 5'd17;
    localparam logic [4:0] BS_CHI  = 5'd18;
    localparam logic [4:0] BS_EF   = 5'd19;
    localparam logic [4:0] BS_EP   = 5'd20;

    logic [4:0]           r_st;
    logic                 r_iss, r_zs, r_ovf, r_lastp, r_csat, r_fitok;
    logic [CW-1:0]        r_cnt, r_i;
    logic signed [23:0]   r_cx, r_cy;
    logic [31:0]          r_cw;
    logic signed [63:0]   r_wx, r_x, r_y;
    logic [39:0]          r_s;
    logic signed [95:0]   r_sxx, r_sxy;
    logic signed [127:0]  r_t, r_den, r_num;
    logic [127:0]         r_acc;
    logic signed [31:0]   r_a, r_b;
    logic signed [47:0]   r_r;
    logic [61:0]          r_m2;
    logic [39:0]          r_chi;
    logic [1:0]           r_status;

    logic signed [23:0]   r_mx [MAX_POINTS];
    logic signed [23:0]   r_my [MAX_POINTS];
    logic [31:0]          r_mw [MAX_POINTS];
    logic [31:0]          r_mres [MAX_POINTS];
    logic signed [23:0]   r_rx, r_ry;
    logic [31:0]          r_rw, r_rres;

    logic                 op_st, op_done, pop_ok, last_i;
    logic [127:0]         prod, pm, at;
    logic [40:0]          srm;
    logic signed [47:0]   srs, sr, rn;
    logic [47:0]          rmag;
    logic                 rbig;
    logic [61:0]          m2;
    logic [31:0]          rs32;
    logic [39:0]          chi_n;

    assign prod    = i_alu_rsp.prod;
    assign pop_ok  = (r_st == BS_IDLE) && !i_q_empty;
    assign o_q_pop = pop_ok;
    assign last_i  = (r_i == r_cnt - CW'(1));
    assign op_done = r_iss && i_alu_rsp.done;

    always_comb begin
        op_st = 1'b1;
        o_alu_req = '0;
        o_alu_req.op = wlfc_pkg::OP_MUL;
        unique case (r_st)
            BS_WX: begin
                o_alu_req.a = {96'd0, r_cw};
                o_alu_req.b = 128'(r_cx);
                o_alu_req.len = LEN_XY;
            end
            BS_WY: begin
                o_alu_req.a = {96'd0, r_cw};
                o_alu_req.b = 128'(r_cy);
                o_alu_req.len = LEN_XY;
            end
            BS_XX: begin
                o_alu_req.a = 128'(r_wx);
                o_alu_req.b = 128'(r_cx);
                o_alu_req.len = LEN_XY;
            end
            BS_XY: begin
                o_alu_req.a = 128'(r_wx);
                o_alu_req.b = 128'(r_cy);
                o_alu_req.len = LEN_XY;
            end
            BS_D1: begin
                o_alu_req.a = 128'(r_sxx);
                o_alu_req.b = {88'd0, r_s};
                o_alu_req.len = LEN_S;
            end
            BS_D2: begin
                o_alu_req.a = 128'(r_x);
                o_alu_req.b = 128'(r_x);
                o_alu_req.len = LEN_X;
            end
            BS_N1: begin
                o_alu_req.a = 128'(r_sxy);
                o_alu_req.b = {88'd0, r_s};
                o_alu_req.len = LEN_S;
            end
            BS_N2: begin
                o_alu_req.a = 128'(r_x);
                o_alu_req.b = 128'(r_y);
                o_alu_req.len = LEN_X;
            end
            BS_B: begin
                o_alu_req.op = wlfc_pkg::OP_DIV;
                o_alu_req.a = r_num;
                o_alu_req.b = r_den;
                o_alu_req.len = LEN_DIV_B;
            end
            BS_XB: begin
                o_alu_req.a = 128'(r_x);
                o_alu_req.b = 128'(r_b);
                o_alu_req.len = LEN_SLOPE;
            end
            BS_A: begin
                o_alu_req.op = wlfc_pkg::OP_DIV;
                o_alu_req.a = r_num;
                o_alu_req.b = {72'd0, r_s, 16'd0};
                o_alu_req.len = LEN_DIV_A;
            end
            BS_BX: begin
                o_alu_req.a = 128'(r_b);
                o_alu_req.b = 128'(r_rx);
                o_alu_req.len = LEN_XY;
            end
            BS_RW: begin
                o_alu_req.a = {66'd0, r_m2};
                o_alu_req.b = {96'd0, r_rw};
                o_alu_req.len = LEN_W;
            end
            default: op_st = 1'b0;
        endcase
        o_alu_req.start = op_st && !r_iss;
    end

    // residual: y - a - round(b*x / 2^16), ties away from zero
    always_comb begin
        pm    = prod[127] ? (~prod + 128'd1) : prod;
        srm   = 41'((57'(pm[55:0]) + 57'd32768) >> 16);
        srs   = 48'(srm);
        sr    = prod[127] ? -srs : srs;
        rn    = 48'(r_ry) - 48'(r_a) - sr;
        rmag  = r_r[47] ? 48'(-r_r) : 48'(r_r);
        rbig  = |rmag[47:31];
        m2    = 62'(rmag[30:0]) * 62'(rmag[30:0]);
        rs32  = (r_r[47:31] == {17{r_r[47]}}) ? r_r[31:0]
              : (r_r[47] ? 32'h8000_0000 : 32'h7FFF_FFFF);
        at    = r_acc + 128'd32768;
        chi_n = (r_csat || (|at[127:56])) ? '1 : at[55:16];
    end

    always_ff @(posedge i_clk) begin
        if (pop_ok && !i_q_data.drop) begin
            r_mx[r_cnt[AW-1:0]] <= i_q_data.x;
            r_my[r_cnt[AW-1:0]] <= i_q_data.y;
            r_mw[r_cnt[AW-1:0]] <= i_q_data.w;
        end
        if (r_st == BS_RSQ) begin
            r_mres[r_i[AW-1:0]] <= rs32;
        end
        r_rx   <= r_mx[r_i[AW-1:0]];
        r_ry   <= r_my[r_i[AW-1:0]];
        r_rw   <= r_mw[r_i[AW-1:0]];
        r_rres <= r_mres[r_i[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= BS_IDLE;
            r_iss   <= 1'b0;
            r_cnt   <= '0;
            r_i     <= '0;
            r_zs    <= 1'b0;
            r_ovf   <= 1'b0;
            r_lastp <= 1'b0;
            r_s     <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_sxx   <= '0;
            r_sxy   <= '0;
        end else begin
            if (op_st && !r_iss) begin
                r_iss <= 1'b1;
            end else if (op_done) begin
                r_iss <= 1'b0;
            end
            unique case (r_st)
                BS_IDLE: begin
                    if (pop_ok) begin
                        r_lastp <= i_q_data.last;
                        if (i_q_data.last) begin
                            r_zs  <= i_q_data.zs;
                            r_ovf <= i_q_data.ovf;
                        end
                        if (!i_q_data.drop) begin
                            r_cx  <= i_q_data.x;
                            r_cy  <= i_q_data.y;
                            r_cw  <= i_q_data.w;
                            r_cnt <= r_cnt + CW'(1);
                            r_st  <= BS_WX;
                        end else if (i_q_data.last) begin
                            r_st <= BS_FIT;
                        end
                    end
                end
                BS_WX: if (op_done) begin
                    r_wx <= $signed(prod[63:0]);
                    r_x  <= r_x + $signed(prod[63:0]);
                    r_st <= BS_WY;
                end
                BS_WY: if (op_done) begin
                    r_y  <= r_y + $signed(prod[63:0]);
                    r_st <= BS_XX;
                end
                BS_XX: if (op_done) begin
                    r_sxx <= r_sxx + $signed(prod[95:0]);
                    r_st  <= BS_XY;
                end
                BS_XY: if (op_done) begin
                    r_sxy <= r_sxy + $signed(prod[95:0]);
                    r_s   <= r_s + 40'(r_cw);
                    r_st  <= r_lastp ? BS_FIT : BS_IDLE;
                end
                BS_FIT: begin
                    if (r_zs) begin
                        r_status <= wlfc_pkg::STAT_ZSIG;
                        r_fitok  <= 1'b0;
                        r_i      <= '0;
                        r_st     <= BS_EF;
                    end else begin
                        r_st <= BS_D1;
                    end
                end
                BS_D1: if (op_done) begin
                    r_t  <= $signed(prod);
                    r_st <= BS_D2;
                end
                BS_D2: if (op_done) begin
                    r_den <= r_t - $signed(prod);
                    r_st  <= BS_N1;
                end
                BS_N1: if (op_done) begin
                    r_t  <= $signed(prod);
                    r_st <= BS_N2;
                end
                BS_N2: if (op_done) begin
                    r_num <= r_t - $signed(prod);
                    r_st  <= BS_CHK;
                end
                BS_CHK: begin
                    if (r_den == '0) begin
                        r_status <= wlfc_pkg::STAT_DEGEN;
                        r_fitok  <= 1'b0;
                        r_i      <= '0;
                        r_st     <= BS_EF;
                    end else begin
                        r_st <= BS_B;
                    end
                end
                BS_B: if (op_done) begin
                    r_b  <= $signed(i_alu_rsp.quot);
                    r_st <= BS_XB;
                end
                BS_XB: if (op_done) begin
                    r_num <= (128'(r_y) <<< 16) - $signed(prod);
                    r_st  <= BS_A;
                end
                BS_A: if (op_done) begin
                    r_a    <= $signed(i_alu_rsp.quot);
                    r_i    <= '0;
                    r_acc  <= '0;
                    r_csat <= 1'b0;
                    r_st   <= BS_RF;
                end
                BS_RF: r_st <= BS_BX;
                BS_BX: if (op_done) begin
                    r_r  <= rn;
                    r_st <= BS_RSQ;
                end
                BS_RSQ: begin
                    r_m2 <= m2;
                    if (!rbig) begin
                        r_st <= BS_RW;
                    end else begin
                        r_csat <= 1'b1;
                        if (last_i) begin
                            r_st <= BS_CHI;
                        end else begin
                            r_i  <= r_i + CW'(1);
                            r_st <= BS_RF;
                        end
                    end
                end
                BS_RW: if (op_done) begin
                    r_acc <= r_acc + prod;
                    if (last_i) begin
                        r_st <= BS_CHI;
                    end else begin
                        r_i  <= r_i + CW'(1);
                        r_st <= BS_RF;
                    end
                end
                BS_CHI: begin
                    r_chi    <= chi_n;
                    r_status <= r_ovf ? wlfc_pkg::STAT_OVER : wlfc_pkg::STAT_OK;
                    r_fitok  <= 1'b1;
                    r_i      <= '0;
                    r_st     <= BS_EF;
                end
                BS_EF: r_st <= BS_EP;
                BS_EP: begin
                    if (!i_r_full) begin
                        if (last_i) begin
                            r_cnt   <= '0;
                            r_i     <= '0;
                            r_zs    <= 1'b0;
                            r_ovf   <= 1'b0;
                            r_lastp <= 1'b0;
                            r_s     <= '0;
                            r_x     <= '0;
                            r_y     <= '0;
                            r_sxx   <= '0;
                            r_sxy   <= '0;
                            r_st    <= BS_IDLE;
                        end else begin
                            r_i  <= r_i + CW'(1);
                            r_st <= BS_EF;
                        end
                    end
                end
                default: r_st <= BS_IDLE;
            endcase
        end
    end

    assign o_r_push        = (r_st == BS_EP);
    assign o_r_data.chi    = r_fitok ? r_chi : '0;
    assign o_r_data.a      = r_fitok ? r_a : '0;
    assign o_r_data.b      = r_fitok ? r_b : '0;
    assign o_r_data.res    = r_fitok ? $signed(r_rres) : '0;
    assign o_r_data.idx    = 3'(r_i);
    assign o_r_data.status = r_status;
    assign o_r_data.last   = last_i;
endmodule

FILE: src/weighted_line_fit_chi2.sv
// Weighted straight-line fit y = a + b*x with chi-square.
// Input channel (push/full): one point per beat, x and y Q16.8, sigma Q4.12,
// last_point closes the set. Points past MAX_POINTS are dropped (status 3).
// Output channel (empty/pop): after the closing beat, one result per stored
// point in index order, each with chi2, a, b, its residual and a status;
// last_result marks the final one.
// The front takes one point at a time and computes the 1/sigma^2 weight of
// each stored point (4 quotient bits per cycle); it takes no new point until
// the last one has gone into the point queue, and it waits while that is full.
// The back folds each point into its sums with four shift-add multiplies
// on the shared arithmetic unit; the fit then computes the slope, the
// intercept and each point's residual and chi2 term, and the results follow
// one by one. The 4-entry point queue lets loading continue while it works.
// When pop is held low the 2-entry result queue fills and the back waits;
// the front keeps loading until the point queue is full.
// Reset (synchronous, active low) empties both queues and starts a new set.
module weighted_line_fit_chi2 #(
    parameter int MAX_POINTS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [23:0] i_point_x,
    input  logic signed [23:0] i_point_y,
    input  logic [15:0]        i_point_sigma,
    input  logic               i_last_point,
    output logic               empty,
    input  logic               pop,
    output logic [39:0]        o_chi_square,
    output logic signed [31:0] o_intercept,
    output logic signed [31:0] o_slope,
    output logic signed [31:0] o_residual,
    output logic [2:0]         o_point_index,
    output logic [1:0]         o_status,
    output logic               o_last_result
);
    localparam int PTW  = $bits(wlfc_pkg::t_pt);
    localparam int RSW  = $bits(wlfc_pkg::t_res);

    wlfc_pkg::t_pt      f_data, q_data;
    wlfc_pkg::t_res     b_data, o_data;
    wlfc_pkg::t_alu_req alu_req;
    wlfc_pkg::t_alu_rsp alu_rsp;
    logic               f_push, q_full, q_empty, q_pop;
    logic               r_push, r_full;

    wlfc_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_x      (i_point_x),
        .i_y      (i_point_y),
        .i_sigma  (i_point_sigma),
        .i_last   (i_last_point),
        .o_q_push (f_push),
        .o_q_data (f_data),
        .i_q_full (q_full)
    );

    wlfc_fifo #(.WIDTH(PTW), .DEPTH(4)) u_ptq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    wlfc_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    wlfc_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_q_data  (q_data),
        .o_alu_req (alu_req),
        .i_alu_rsp (alu_rsp),
        .o_r_push  (r_push),
        .o_r_data  (b_data),
        .i_r_full  (r_full)
    );

    wlfc_fifo #(.WIDTH(RSW), .DEPTH(2)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_push),
        .i_data  (b_data),
        .o_full  (r_full),
        .i_pop   (pop),
        .o_data  (o_data),
        .o_empty (empty)
    );

    assign o_chi_square  = o_data.chi;
    assign o_intercept   = o_data.a;
    assign o_slope       = o_data.b;
    assign o_residual    = o_data.res;
    assign o_point_index = o_data.idx;
    assign o_status      = o_data.status;
    assign o_last_result = o_data.last;
endmodule

FILE: tb/weighted_line_fit_chi2_tb.sv
module weighted_line_fit_chi2_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   NPTS      = 8;
    localparam int   ITEMS     = 180;
    localparam int   IDLE_MAX  = 20000;
    localparam int   TAIL_CYC  = 1500;
    localparam int   HOLD_CYC  = 6000;
    localparam logic [39:0] CHI_SAT = 40'hFF_FFFF_FFFF;

    class fit_scoreboard;
        longint          pt_x[NPTS];
        longint          pt_y[NPTS];
        longint unsigned pt_sg[NPTS];
        int              n_pts;
        bit              dropped;
        bit              zero_sg;
        wlfc_pkg::t_res  pending[$];
        int              errors;

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        function automatic longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // round(num * 2^extra / den), ties away from zero, saturated to 32 bits
        function automatic longint div_round(logic signed [191:0] num,
                                             logic signed [191:0] den, int extra);
            bit           neg;
            logic [191:0] mag;
            logic [191:0] q;
            neg = num < 0;
            mag = neg ? 192'(-num) : 192'(num);
            q = (mag << (extra + 1)) / 192'(den);
            if (q >= (192'd1 << 40)) return neg ? -64'sd2147483648 : 64'sd2147483647;
            q = (q + 1) >> 1;
            if (neg) return (q > 192'd2147483648) ? -64'sd2147483648 : -longint'(q);
            return (q > 192'd2147483647) ? 64'sd2147483647 : longint'(q);
        endfunction

        function automatic void fit_set();
            longint unsigned     wt[NPTS];
            logic signed [191:0] sum_w, sum_x, sum_y, den, num, wi, wj, dx, dy, bb;
            logic [191:0]        acc;
            logic [191:0]        chi_w;
            longint              a, b, r, bx, mb;
            longint              resid[NPTS];
            longint unsigned     m;
            bit                  csat;
            logic [1:0]          st;
            wlfc_pkg::t_res      e;
            sum_w = 0; sum_x = 0; sum_y = 0; den = 0; num = 0; acc = 0;
            a = 0; b = 0; csat = 0; chi_w = 0;
            for (int i = 0; i < NPTS; i++) resid[i] = 0;
            st = zero_sg ? wlfc_pkg::STAT_ZSIG : wlfc_pkg::STAT_OK;
            if (st == wlfc_pkg::STAT_OK) begin
                for (int i = 0; i < n_pts; i++) begin
                    wt[i] = 64'hFFFF_FFFF / (pt_sg[i] * pt_sg[i]);
                    wi = wt[i];
                    sum_w += wi;
                    sum_x += wi * pt_x[i];
                    sum_y += wi * pt_y[i];
                end
                for (int i = 0; i < n_pts; i++) begin
                    for (int j = i + 1; j < n_pts; j++) begin
                        wi = wt[i];
                        wj = wt[j];
                        dx = pt_x[i] - pt_x[j];
                        dy = pt_y[i] - pt_y[j];
                        den += wi * wj * dx * dx;
                        num += wi * wj * dx * dy;
                    end
                end
                if (den == 0) begin
                    st = wlfc_pkg::STAT_DEGEN;
                end else begin
                    b = div_round(num, den, 16);
                    bb = b;
                    a = div_round(sum_y * 65536 - sum_x * bb, sum_w * 65536, 0);
                    for (int i = 0; i < n_pts; i++) begin
                        bx = b * pt_x[i];
                        mb = ((bx < 0 ? -bx : bx) + 32768) >>> 16;
                        resid[i] = pt_y[i] - a - (bx < 0 ? -mb : mb);
                        m = resid[i] < 0 ? -resid[i] : resid[i];
                        if (m >= 64'd2147483648) csat = 1;
                        else acc += 192'(m * m) * 192'(wt[i]);
                    end
                    chi_w = (acc + 32768) >> 16;
                    if (csat || chi_w > 192'(CHI_SAT)) chi_w = CHI_SAT;
                    if (dropped) st = wlfc_pkg::STAT_OVER;
                end
            end
            if (st == wlfc_pkg::STAT_ZSIG || st == wlfc_pkg::STAT_DEGEN) begin
                a = 0; b = 0; chi_w = 0;
            end
            for (int i = 0; i < n_pts; i++) begin
                e.chi    = chi_w[39:0];
                e.a      = a[31:0];
                e.b      = b[31:0];
                e.res    = 32'(clamp32(resid[i]));
                e.idx    = i[2:0];
                e.status = st;
                e.last   = (i == n_pts - 1);
                pending = {pending, e};
            end
            n_pts = 0;
            dropped = 0;
            zero_sg = 0;
        endfunction

        function void note_point(logic signed [23:0] x, logic signed [23:0] y,
                                 logic [15:0] sg, logic last);
            if (n_pts < NPTS) begin
                pt_x[n_pts] = x;
                pt_y[n_pts] = y;
                pt_sg[n_pts] = sg;
                if (sg == 0) zero_sg = 1;
                n_pts++;
            end else begin
                dropped = 1;
            end
            if (last) fit_set();
        endfunction

        task check(wlfc_pkg::t_res got);
            wlfc_pkg::t_res e;
            if (pending.size() == 0) begin
                report("unexpected beat, index", got.idx, -1);
            end else begin
                e = pending.pop_front();
                if (got.chi !== e.chi) report("chi_square", got.chi, e.chi);
                if (got.a !== e.a) report("intercept", got.a, e.a);
                if (got.b !== e.b) report("slope", got.b, e.b);
                if (got.res !== e.res) report("residual", got.res, e.res);
                if (got.idx !== e.idx) report("point_index", got.idx, e.idx);
                if (got.status !== e.status) report("status", got.status, e.status);
                if (got.last !== e.last) report("last_result", got.last, e.last);
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic signed [23:0] i_point_x;
    logic signed [23:0] i_point_y;
    logic [15:0]        i_point_sigma;
    logic               i_last_point;
    logic               empty;
    logic               pop;
    logic [39:0]        o_chi_square;
    logic signed [31:0] o_intercept;
    logic signed [31:0] o_slope;
    logic signed [31:0] o_residual;
    logic [2:0]         o_point_index;
    logic [1:0]         o_status;
    logic               o_last_result;

    weighted_line_fit_chi2 dut (.*);

    fit_scoreboard sb = new();
    int  n_sent;
    int  idle_cyc;
    bit  quiet;
    bit  hold_req;
    bit  did_hold;
    bit  did_drain;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // monitor: points in, result beats out
    always @(posedge i_clk) begin
        wlfc_pkg::t_res got;
        if (i_rst_n && push && !full) begin
            sb.note_point(i_point_x, i_point_y, i_point_sigma, i_last_point);
        end
        if (i_rst_n && pop && !empty) begin
            got.chi    = o_chi_square;
            got.a      = o_intercept;
            got.b      = o_slope;
            got.res    = o_residual;
            got.idx    = o_point_index;
            got.status = o_status;
            got.last   = o_last_result;
            sb.check(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= IDLE_MAX) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        pop = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                pop <= 0;
                repeat (HOLD_CYC) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                pop <= 0;
                repeat ($urandom_range(0, 14)) @(negedge i_clk);
            end else begin
                pop <= 1;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the beat
    task send_point(logic signed [23:0] x, logic signed [23:0] y,
                    logic [15:0] sg, logic last);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            push <= 0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        push <= 1;
        i_point_x <= x;
        i_point_y <= y;
        i_point_sigma <= sg;
        i_last_point <= last;
        do @(posedge i_clk); while (full);
        n_sent++;
        @(negedge i_clk);
    endtask

    task wait_drained();
        push <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    task send_random_set();
        int                 n, mode;
        logic signed [23:0] x0, x, y, k;
        logic [15:0]        sg;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
        mode = $urandom_range(0, 3);
        x0 = 24'($urandom);
        k = $signed(24'($urandom_range(0, 1023))) - 512;
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: begin
                    x = 24'($urandom);
                    y = 24'($urandom);
                end
                1: begin
                    x = $signed(24'($urandom_range(0, 8191))) - 4096;
                    y = x * k / 64 + $signed(24'($urandom_range(0, 511))) - 256;
                end
                2: begin
                    x = x0;
                    y = 24'($urandom);
                end
                default: begin
                    x = $signed(24'($urandom_range(0, 262143))) - 131072;
                    y = $signed(24'($urandom_range(0, 262143))) - 131072;
                end
            endcase
            if ($urandom_range(0, 24) == 0) sg = 0;
            else if ($urandom_range(0, 1)) sg = 16'($urandom_range(1, 65535));
            else sg = 16'($urandom_range(256, 8192));
            send_point(x, y, sg, i == n - 1);
        end
    endtask

    initial begin
        i_rst_n = 0;
        push = 0;
        i_point_x = 0;
        i_point_y = 0;
        i_point_sigma = 0;
        i_last_point = 0;
        n_sent = 0;
        quiet = 0;
        hold_req = 0;
        did_hold = 0;
        did_drain = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // field extremes
        send_point(-24'sd8388608, 24'sd8388607, 16'd1, 0);
        send_point(24'sd8388607, -24'sd8388608, 16'd65535, 1);
        // clean line, three points
        send_point(-24'sd2560, -24'sd1024, 16'd4096, 0);
        send_point(24'sd0, 24'sd256, 16'd2048, 0);
        send_point(24'sd2560, 24'sd1536, 16'd4096, 1);
        // zero sigma suppresses the fit
        send_point(24'sd100, 24'sd200, 16'd0, 0);
        send_point(24'sd300, 24'sd400, 16'd4096, 1);
        // all points on one abscissa
        send_point(24'sd777, 24'sd1, 16'd100, 0);
        send_point(24'sd777, -24'sd50, 16'd200, 0);
        send_point(24'sd777, 24'sd9000, 16'd300, 1);
        // lone point
        send_point(-24'sd5, 24'sd5, 16'd4096, 1);
        // beyond capacity; the dropped zero sigma must not count
        for (int i = 0; i < 10; i++) begin
            send_point(24'(i * 1000 - 4000), 24'(i * 300), (i == 8) ? 16'd0 : 16'd3000,
                       i == 9);
        end
        wait_drained();

        while (n_sent < ITEMS) begin
            if (!did_hold && n_sent > 60) begin
                // stall the result side while a full set streams in
                hold_req = 1;
                for (int i = 0; i < NPTS; i++) begin
                    send_point(24'(i * 517 - 1500), 24'($urandom_range(0, 4095)),
                               16'($urandom_range(500, 6000)), i == NPTS - 1);
                end
                send_random_set();
                send_random_set();
                did_hold = 1;
            end
            if (!did_drain && n_sent > 120) begin
                wait_drained();
                did_drain = 1;
            end
            quiet = (n_sent > 150);
            send_random_set();
        end
        wait_drained();
        repeat (TAIL_CYC) @(negedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
